// ===== sv/gbn_pkg.sv =====
// Shared types and constants for the greedy box NMS block.
// Used by gbn_cell and greedy_box_nms; depends on nothing else.
package gbn_pkg;

   localparam int POS_W  = 12;               // signed box edge
   localparam int SIDE_W = 11;               // unsigned box width / height
   localparam int AREA_W = 2 * SIDE_W;       // w * h
   localparam int THR_W  = 16;               // Q0.16 IoU threshold
   localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

   // request payload: x, y, w, h from the lowest bit up
   localparam int BOX_W   = 2 * POS_W + 2 * SIDE_W;
   localparam int REQ_DW  = ((BOX_W + 7) / 8) * 8;

   // cycles from a query entering a cell to that cell's verdict
   localparam int CELL_LAT = 4;

   typedef struct packed {
      logic        [SIDE_W-1:0] h;
      logic        [SIDE_W-1:0] w;
      logic signed [POS_W-1:0]  y;
      logic signed [POS_W-1:0]  x;
   } box_type;

   // query box moving down the chain
   typedef struct packed {
      logic               valid;
      box_type            box;
      logic [AREA_W-1:0]  area;
   } query_type;

   // running suppress verdict, trailing the query down the chain
   typedef struct packed {
      logic valid;
      logic suppress;
   } flag_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AREA,
      ST_LAUNCH,
      ST_RUN,
      ST_DONE
   } state_type;

endpackage

// ===== sv/gbn_cell.sv =====
// One cell of the NMS chain: holds one kept box, compares the passing query.
// Depends on gbn_pkg.
module gbn_cell
   import gbn_pkg::*;
#(
   parameter int CNT_W = 7,
   parameter int IDX   = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [THR_W-1:0]  thr,
   input  logic [CNT_W-1:0]  count,
   input  query_type         q_i,
   output query_type         q_o,
   input  flag_type          f_i,
   output flag_type          f_o,
   input  logic              wr_en,
   input  box_type           wr_box,
   input  logic [AREA_W-1:0] wr_area
);

   // overlap length of two spans, zero when they do not overlap
   function automatic logic [SIDE_W-1:0] overlap(
      input logic signed [POS_W-1:0] a0,
      input logic        [SIDE_W-1:0] alen,
      input logic signed [POS_W-1:0] b0,
      input logic        [SIDE_W-1:0] blen
   );
      logic signed [POS_W+1:0] ea0, eb0, a1, b1, lo, hi, d;
      ea0 = {{2{a0[POS_W-1]}}, a0};
      eb0 = {{2{b0[POS_W-1]}}, b0};
      a1  = ea0 + $signed({3'b000, alen});
      b1  = eb0 + $signed({3'b000, blen});
      lo  = (ea0 > eb0) ? ea0 : eb0;
      hi  = (a1 < b1) ? a1 : b1;
      d   = hi - lo;
      return (hi > lo) ? d[SIDE_W-1:0] : '0;
   endfunction

   query_type                q_ff;
   box_type                  st_box_ff;
   logic [AREA_W-1:0]        st_area_ff;

   logic                     act1_ff;
   logic [SIDE_W-1:0]        ovw_ff, ovh_ff;
   logic [AREA_W:0]          asum1_ff;

   logic                     act2_ff;
   logic [AREA_W-1:0]        inter2_ff;
   logic [AREA_W:0]          asum2_ff;

   logic                     act3_ff, nz3_ff;
   logic [AREA_W+THR_W-1:0]  lhs3_ff;
   logic [AREA_W+THR_W:0]    rhs3_ff;

   logic [AREA_W:0]          uni;
   logic                     verdict;
   flag_type                 f_ff;

   // pass the query to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff.valid <= 1'b0;
      end else begin
         q_ff.valid <= q_i.valid;
      end
      q_ff.box  <= q_i.box;
      q_ff.area <= q_i.area;
   end

   assign q_o = q_ff;

   // hold the stored box
   always_ff @(posedge clock) begin
      if (wr_en && count == CNT_W'(IDX)) begin
         st_box_ff  <= wr_box;
         st_area_ff <= wr_area;
      end
   end

   // stage 1: overlap spans and area sum
   always_ff @(posedge clock) begin
      if (reset) begin
         act1_ff <= 1'b0;
      end else begin
         act1_ff <= q_ff.valid && (CNT_W'(IDX) < count);
      end
      ovw_ff   <= overlap(q_ff.box.x, q_ff.box.w, st_box_ff.x, st_box_ff.w);
      ovh_ff   <= overlap(q_ff.box.y, q_ff.box.h, st_box_ff.y, st_box_ff.h);
      asum1_ff <= {1'b0, q_ff.area} + {1'b0, st_area_ff};
   end

   // stage 2: intersection area
   always_ff @(posedge clock) begin
      if (reset) begin
         act2_ff <= 1'b0;
      end else begin
         act2_ff <= act1_ff;
      end
      inter2_ff <= AREA_W'(ovw_ff) * AREA_W'(ovh_ff);
      asum2_ff  <= asum1_ff;
   end

   // stage 3: union and threshold products
   assign uni = asum2_ff - {1'b0, inter2_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         act3_ff <= 1'b0;
      end else begin
         act3_ff <= act2_ff;
      end
      lhs3_ff <= {inter2_ff, {THR_W{1'b0}}};
      rhs3_ff <= (AREA_W+THR_W+1)'(thr) * (AREA_W+THR_W+1)'(uni);
      nz3_ff  <= (uni != '0);
   end

   // merge this cell's verdict into the running flag
   assign verdict = act3_ff && nz3_ff && ({1'b0, lhs3_ff} > rhs3_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         f_ff.valid    <= 1'b0;
         f_ff.suppress <= 1'b0;
      end else begin
         f_ff.valid    <= f_i.valid;
         f_ff.suppress <= f_i.suppress | verdict;
      end
   end

   assign f_o = f_ff;

endmodule

// ===== sv/greedy_box_nms.sv =====
// Greedy IoU non-maximum suppression over a chain of MAX_KEPT compare cells.
// Requests are taken one at a time: each passes the area, launch, run and done steps
// before the next is accepted; the query walks one cell a cycle.
// Reset empties the kept list, zeroes the frame position and loads threshold 29491.
// Depends on gbn_pkg and gbn_cell.
module greedy_box_nms
   import gbn_pkg::*;
#(
   parameter int MAX_KEPT  = 64,
   parameter int MAX_BOXES = 16384,
   localparam int CNT_W   = $clog2(MAX_KEPT + 1),
   localparam int IDX_W   = $clog2(MAX_BOXES),
   localparam int RSP_DW  = ((2 + IDX_W + CNT_W + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   // configuration: IoU threshold, Q0.16
   input  logic              csr_wen,
   input  logic [THR_W-1:0]  csr_wdata,
   // request channel
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [REQ_DW-1:0] req_tdata,   // box_x, box_y, box_w, box_h
   input  logic              req_tuser,   // frame_start
   // response channel
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_DW-1:0] rsp_tdata    // keep, box_index, kept_total, store_overflow
);

   state_type              state_ff, state_in;
   logic [THR_W-1:0]       thr_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [IDX_W-1:0]       pos_ff;
   logic [IDX_W-1:0]       index_ff;
   box_type                box_ff;
   logic [AREA_W-1:0]      area_ff;
   logic [CELL_LAT-1:0]    fd_ff;
   logic                   keep_ff;
   logic                   rsp_tvalid_ff;
   logic [RSP_DW-1:0]      rsp_data_ff;

   logic                   launch, rsp_load, store_en, ovf, accept;
   logic [IDX_W-1:0]       index_in, pos_in;
   logic [CNT_W-1:0]       count_start, count_next;

   query_type              q_link [MAX_KEPT+1];
   flag_type               f_link [MAX_KEPT+1];

   assign accept = req_tvalid && req_tready;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_wen) begin
         thr_ff <= csr_wdata;
      end
   end

   // sequencer: next state and strobes
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      launch     = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) state_in = ST_AREA;
         end
         ST_AREA: begin
            state_in = ST_LAUNCH;
         end
         ST_LAUNCH: begin
            launch   = 1'b1;
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (f_link[MAX_KEPT].valid) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // frame bookkeeping at accept
   assign index_in    = req_tuser ? '0 : pos_ff;
   assign pos_in      = (index_in == IDX_W'(MAX_BOXES - 1)) ? '0 : index_in + 1'b1;
   assign count_start = req_tuser ? '0 : count_ff;

   // store decision at response load
   assign store_en   = rsp_load && keep_ff && (count_ff < CNT_W'(MAX_KEPT));
   assign ovf        = keep_ff && (count_ff == CNT_W'(MAX_KEPT));
   assign count_next = count_ff + CNT_W'(store_en);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pos_ff   <= '0;
      end else if (accept) begin
         count_ff <= count_start;
         pos_ff   <= pos_in;
      end else if (store_en) begin
         count_ff <= count_next;
      end
   end

   // hold the request box and its area
   always_ff @(posedge clock) begin
      if (accept) begin
         box_ff   <= box_type'(req_tdata[BOX_W-1:0]);
         index_ff <= index_in;
      end
      if (state_ff == ST_AREA) begin
         area_ff <= AREA_W'(box_ff.w) * AREA_W'(box_ff.h);
      end
   end

   // delay the flag launch to meet the first cell's verdict
   always_ff @(posedge clock) begin
      if (reset) begin
         fd_ff <= '0;
      end else begin
         fd_ff <= {fd_ff[CELL_LAT-2:0], launch};
      end
   end

   assign q_link[0] = '{valid: launch, box: box_ff, area: area_ff};
   assign f_link[0] = '{valid: fd_ff[CELL_LAT-1], suppress: 1'b0};

   // chain of compare cells, one per kept entry
   for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
      gbn_cell #(
         .CNT_W (CNT_W),
         .IDX   (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .thr     (thr_ff),
         .count   (count_ff),
         .q_i     (q_link[i]),
         .q_o     (q_link[i+1]),
         .f_i     (f_link[i]),
         .f_o     (f_link[i+1]),
         .wr_en   (store_en),
         .wr_box  (box_ff),
         .wr_area (area_ff)
      );
   end

   // capture the final verdict
   always_ff @(posedge clock) begin
      if (state_ff == ST_RUN && f_link[MAX_KEPT].valid) begin
         keep_ff <= !f_link[MAX_KEPT].suppress;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_tvalid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_ff <= 1'b0;
      end
      if (rsp_load) begin
         rsp_data_ff <= RSP_DW'({ovf, count_next, index_ff, keep_ff});
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   a_flag_in_run: assert property (@(posedge clock) disable iff (reset)
      f_link[MAX_KEPT].valid |-> state_ff == ST_RUN)
      else $error("final verdict outside run state");

   a_query_in_run: assert property (@(posedge clock) disable iff (reset)
      q_link[MAX_KEPT].valid |-> state_ff == ST_RUN)
      else $error("query left the chain outside run state");

   a_store_room: assert property (@(posedge clock) disable iff (reset)
      store_en |-> count_ff < CNT_W'(MAX_KEPT))
      else $error("store write with full kept list");

   a_accept_area: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_AREA)
      else $error("accepted request did not start area step");

endmodule

// ===== tb/greedy_box_nms_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for greedy_box_nms: streams boxes under several IoU thresholds,
// predicts every keep/suppress response and compares it field by field.
// Depends on gbn_pkg and the greedy_box_nms RTL; reads no files.
module greedy_box_nms_tb;
   import gbn_pkg::*;

   localparam int PERIOD     = 10;
   localparam int KEPT_DEPTH = 64;
   localparam int FRAME_MOD  = 16384;
   localparam int RSP_W      = 24;
   localparam int ITEMS      = 400;
   localparam int LONG_HOLD  = 400;
   localparam int SETTLE     = 100;
   localparam int GRID_SIDE  = 16;
   localparam int CELL_PX    = 256;
   localparam int POS_MIN    = -(1 << (POS_W - 1));
   localparam int POS_MAX    = (1 << (POS_W - 1)) - 1;
   localparam int SIDE_MAX   = (1 << SIDE_W) - 1;

   // response fields from the lowest bit up
   typedef struct packed {
      logic        store_overflow;
      logic [6:0]  kept_total;
      logic [13:0] box_index;
      logic        keep;
   } verdict_type;

   typedef enum int {
      FRAME_GRID,
      FRAME_CLUSTER,
      FRAME_NOISE
   } frame_kind_type;

   // Predicts the NMS verdict of each accepted box and checks the responses.
   class nms_scoreboard;
      logic [THR_W-1:0] threshold;
      box_type          kept_box [KEPT_DEPTH];
      longint unsigned  kept_area [KEPT_DEPTH];
      int unsigned      kept_count;
      int unsigned      position;
      verdict_type      verdicts [$];
      int               boxes_seen;
      int               errors;

      function new();
         threshold  = THR_RESET;
         kept_count = 0;
         position   = 0;
         boxes_seen = 0;
         errors     = 0;
      endfunction

      function int pending();
         return verdicts.size();
      endfunction

      // overlap of two spans, zero when they only touch or are apart
      function longint unsigned span_overlap(logic signed [POS_W-1:0] a0,
                                             logic [SIDE_W-1:0] alen,
                                             logic signed [POS_W-1:0] b0,
                                             logic [SIDE_W-1:0] blen);
         int lo, hi, a1, b1;
         a1 = int'(a0) + int'(alen);
         b1 = int'(b0) + int'(blen);
         lo = (int'(a0) > int'(b0)) ? int'(a0) : int'(b0);
         hi = (a1 < b1) ? a1 : b1;
         return (hi > lo) ? longint'(hi - lo) : 0;
      endfunction

      // walk the kept list and work out the response for one box
      function void note_box(logic frame_start, box_type b);
         verdict_type     v;
         longint unsigned area, inter, uni;
         logic            suppressed;
         if (frame_start) begin
            kept_count = 0;
            position   = 0;
         end
         v.box_index = position[13:0];
         position    = (position + 1) % FRAME_MOD;
         area        = longint'(b.w) * longint'(b.h);
         suppressed  = 1'b0;
         for (int i = 0; i < kept_count; i++) begin
            inter = span_overlap(b.x, b.w, kept_box[i].x, kept_box[i].w) *
                    span_overlap(b.y, b.h, kept_box[i].y, kept_box[i].h);
            uni   = area + kept_area[i] - inter;
            // zero union never suppresses
            if (uni != 0 && (inter << 16) > threshold * uni) suppressed = 1'b1;
         end
         v.keep           = !suppressed;
         v.store_overflow = 1'b0;
         if (!suppressed) begin
            if (kept_count < KEPT_DEPTH) begin
               kept_box[kept_count]  = b;
               kept_area[kept_count] = area;
               kept_count++;
            end else begin
               v.store_overflow = 1'b1;
            end
         end
         v.kept_total = kept_count[6:0];
         verdicts = {verdicts, v};
         boxes_seen++;
      endfunction

      task report(string what, int got, int want);
         $display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
         errors++;
      endtask

      // compare one response with the oldest prediction
      task check_result(logic [RSP_W-1:0] data);
         verdict_type got, want;
         got = verdict_type'(data[$bits(verdict_type)-1:0]);
         if (verdicts.size() == 0) begin
            report("unexpected response, box_index", got.box_index, -1);
            return;
         end
         want = verdicts.pop_front();
         if (got.keep !== want.keep) report("keep", got.keep, want.keep);
         if (got.box_index !== want.box_index)
            report("box_index", got.box_index, want.box_index);
         if (got.kept_total !== want.kept_total)
            report("kept_total", got.kept_total, want.kept_total);
         if (got.store_overflow !== want.store_overflow)
            report("store_overflow", got.store_overflow, want.store_overflow);
      endtask
   endclass

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              csr_wen    = 1'b0;
   logic [THR_W-1:0]  csr_wdata  = '0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [REQ_DW-1:0] req_tdata  = '0;   // box_x, box_y, box_w, box_h
   logic              req_tuser  = 1'b0; // frame_start
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;         // keep, box_index, kept_total, store_overflow

   nms_scoreboard sb = new();
   int            accepted    = 0;
   int            burst_left  = 0;
   bit            hold_asked  = 1'b0;

   greedy_box_nms #(
      .MAX_KEPT  (KEPT_DEPTH),
      .MAX_BOXES (FRAME_MOD)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #(PERIOD / 2) clock = ~clock;

   // observe handshakes and register writes at each rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_wen) sb.threshold = csr_wdata;
         if (req_tvalid && req_tready) sb.note_box(req_tuser, box_type'(req_tdata[BOX_W-1:0]));
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);
      end
   end

   // pace the response side: random modes, plus one long hold-off on demand
   initial begin : rsp_pacing
      int mode, mode_left, hold_left;
      mode      = 0;
      mode_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_asked) begin
            hold_asked = 1'b0;
            hold_left  = LONG_HOLD;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 2);
            mode_left = $urandom_range(20, 300);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 1) == 1);
               default: rsp_tready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   function automatic int clip(int v, int lo, int hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic box_type make_box(int x, int y, int w, int h);
      box_type b;
      b.x = POS_W'(clip(x, POS_MIN, POS_MAX));
      b.y = POS_W'(clip(y, POS_MIN, POS_MAX));
      b.w = SIDE_W'(clip(w, 0, SIDE_MAX));
      b.h = SIDE_W'(clip(h, 0, SIDE_MAX));
      return b;
   endfunction

   // offer one request in bursts with random gaps; return once it is accepted
   task automatic push_box(logic frame_start, box_type b);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 8);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= frame_start;
      req_tdata  <= REQ_DW'(b);
      do @(posedge clock); while (!req_tready);
      accepted++;
   endtask

   // stop offering and hold until every accepted box has its response
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (sb.boxes_seen != accepted || sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_threshold(logic [THR_W-1:0] value);
      wait_idle();
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
   endtask

   initial begin
      int          frames, length, base, slot, ox, oy, c;
      int          cx [3], cy [3], cw [3], ch [3];
      logic        open;
      frame_kind_type kind;
      logic [THR_W-1:0] thr;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // no frame_start straight after reset: boxes continue the power-up frame
      push_box(1'b0, make_box(0, 0, 10, 10));
      push_box(1'b0, make_box(0, 0, 10, 10));
      // extremes of every field
      push_box(1'b1, make_box(POS_MIN, POS_MIN, SIDE_MAX, SIDE_MAX));
      push_box(1'b0, make_box(POS_MAX, POS_MAX, SIDE_MAX, SIDE_MAX));
      push_box(1'b0, make_box(-1, -1, 2, 2));
      push_box(1'b0, make_box(POS_MAX, POS_MIN, 1, 0));
      // zero-area pairs: a zero union never suppresses
      push_box(1'b1, make_box(5, 5, 0, 0));
      push_box(1'b0, make_box(5, 5, 0, 0));
      push_box(1'b0, make_box(5, 5, 0, 7));
      // touching edges, then overlaps above and below the default threshold
      push_box(1'b1, make_box(0, 0, 100, 100));
      push_box(1'b0, make_box(100, 0, 100, 100));
      push_box(1'b0, make_box(30, 0, 100, 100));
      push_box(1'b0, make_box(50, 0, 100, 100));

      // threshold zero: any overlap at all suppresses
      write_threshold('0);
      push_box(1'b1, make_box(0, 0, 50, 50));
      push_box(1'b0, make_box(49, 49, 50, 50));
      push_box(1'b0, make_box(50, 0, 50, 50));
      push_box(1'b0, make_box(0, 0, 0, 0));

      // threshold at full scale: an exact copy suppresses, a one-pixel shift does not
      write_threshold('1);
      push_box(1'b1, make_box(100, 100, 300, 300));
      push_box(1'b0, make_box(100, 100, 300, 300));
      push_box(1'b0, make_box(101, 100, 300, 300));

      write_threshold(THR_RESET);

      // random frames: disjoint grids that fill the store, clusters, and noise
      frames = 0;
      while (accepted < ITEMS) begin
         if (frames % 4 == 3) begin
            case ($urandom_range(0, 4))
               0: thr = '0;
               1: thr = '1;
               2: thr = THR_RESET;
               default: thr = THR_W'($urandom_range(0, 65535));
            endcase
            write_threshold(thr);
         end
         // starve the response side while requests keep coming
         if (frames == 4) hold_asked = 1'b1;
         kind = (frames < 2) ? FRAME_GRID : frame_kind_type'($urandom_range(0, 2));
         open = (frames < 2) || ($urandom_range(0, 7) != 0);
         case (kind)
            FRAME_GRID: begin
               length = (frames < 2) ? 70 : $urandom_range(8, 72);
               base   = $urandom_range(0, GRID_SIDE * GRID_SIDE - 1);
               for (int i = 0; i < length; i++) begin
                  slot = (i * 37 + base) % (GRID_SIDE * GRID_SIDE);
                  ox   = $urandom_range(0, 40);
                  oy   = $urandom_range(0, 40);
                  push_box(open && i == 0,
                           make_box(POS_MIN + (slot % GRID_SIDE) * CELL_PX + ox,
                                    POS_MIN + (slot / GRID_SIDE) * CELL_PX + oy,
                                    $urandom_range(0, CELL_PX - ox),
                                    $urandom_range(0, CELL_PX - oy)));
               end
            end
            FRAME_CLUSTER: begin
               for (int k = 0; k < 3; k++) begin
                  cx[k] = int'($urandom_range(0, 3600)) - 1800;
                  cy[k] = int'($urandom_range(0, 3600)) - 1800;
                  cw[k] = $urandom_range(1, 400);
                  ch[k] = $urandom_range(1, 400);
               end
               length = $urandom_range(5, 40);
               for (int i = 0; i < length; i++) begin
                  c = $urandom_range(0, 2);
                  push_box(open && i == 0,
                           make_box(cx[c] + int'($urandom_range(0, 40)) - 20,
                                    cy[c] + int'($urandom_range(0, 40)) - 20,
                                    cw[c] + int'($urandom_range(0, 40)) - 20,
                                    ch[c] + int'($urandom_range(0, 40)) - 20));
               end
            end
            default: begin
               length = $urandom_range(1, 20);
               for (int i = 0; i < length; i++)
                  push_box($urandom_range(0, 5) == 0,
                           make_box(int'($urandom_range(0, 4095)) + POS_MIN,
                                    int'($urandom_range(0, 4095)) + POS_MIN,
                                    $urandom_range(0, SIDE_MAX),
                                    $urandom_range(0, SIDE_MAX)));
            end
         endcase
         frames++;
      end

      wait_idle();
      repeat (SETTLE) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // end the run if the block hangs
   initial begin
      #(5_000_000);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
